// File: sv/dtc_pkg.sv
// ---------------------------------------------------------------------------
// dtc_pkg
// shared widths, constants and the job record passed from front to back
// ---------------------------------------------------------------------------
package dtc_pkg;

    localparam int MAX_STEPS_DEF = 24;
    localparam int FRAC_BITS_DEF = 16;
    localparam int HOURS_PER_DAY = 24;
    localparam int SUB_HOUR      = 16;
    localparam int T_LIMIT       = 4;
    localparam int HOUR_W        = 9;
    localparam int TEMP_W        = 15;
    localparam int IDX_W         = 5;
    localparam logic [IDX_W-1:0] RPD_RESET = 5'd24;

    // positions span about -384 .. 895 in sixteenths of an hour
    localparam int POS_W = 14;

    // one classified day
    typedef struct packed {
        logic signed [POS_W-1:0]  x1;
        logic signed [POS_W-1:0]  x2;
        logic signed [TEMP_W-1:0] y1;
        logic signed [TEMP_W-1:0] y2;
        logic [POS_W-1:0]         period;
        logic [POS_W-1:0]         pstep;
        logic [IDX_W-1:0]         nrec;
        logic                     bad;
    } job_t;

    // step size in sixteenths of an hour: 16 * floor(24 / n)
    function automatic logic [POS_W-1:0] step_len(input logic [IDX_W-1:0] n);
        logic [POS_W-1:0] r;
        case (n)
            5'd1:                      r = POS_W'(384);
            5'd2:                      r = POS_W'(192);
            5'd3:                      r = POS_W'(128);
            5'd4:                      r = POS_W'(96);
            5'd5, 5'd6:                r = POS_W'(64);
            5'd7, 5'd8:                r = POS_W'(48);
            5'd9, 5'd10, 5'd11, 5'd12: r = POS_W'(32);
            // thirteen steps and up: one hour
            default:                   r = POS_W'(SUB_HOUR);
        endcase
        return r;
    endfunction

endpackage

// File: sv/dtc_if.sv
// ---------------------------------------------------------------------------
// dtc_in_if / dtc_out_if
// valid/ready channels for day records and step results
// ---------------------------------------------------------------------------
interface dtc_in_if;
    import dtc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [HOUR_W-1:0]        min_hour;
    logic signed [TEMP_W-1:0] min_temp;
    logic [HOUR_W-1:0]        max_hour;
    logic signed [TEMP_W-1:0] max_temp;
    modport source (output valid, min_hour, min_temp, max_hour, max_temp, input ready);
    modport sink   (input valid, min_hour, min_temp, max_hour, max_temp, output ready);
endinterface

interface dtc_out_if;
    import dtc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] step_temp;
    logic [IDX_W-1:0]         step_index;
    logic                     last_step;
    logic                     bad_hours;
    modport source (output valid, step_temp, step_index, last_step, bad_hours, input ready);
    modport sink   (input valid, step_temp, step_index, last_step, bad_hours, output ready);
endinterface

// File: sv/diurnal_temperature_curve_unit.sv
// ---------------------------------------------------------------------------
// diurnal_temperature_curve_unit
// day min/max records in, interpolated temperature per step out
// ---------------------------------------------------------------------------
// in_ch carries one day per transfer (hours in 1/16 h, temps in 0.01 degC).
// out_ch gives records_per_day transfers per day, step_index counting up and
// last_step marking the final one; bad_hours flags equal min/max hours.
// cfg_we/cfg_wdata set records_per_day (0 reads as 1, above MAX_STEPS clamps);
// write only while idle. Reset sets records_per_day to 24 and empties the queue.
// The front orders knots and queues up to two days; the back handles one step
// at a time: segment select, a restoring divide (cut short when the segment has
// zero length), the multiply states S_T2, S_T3, S_H and S_Y, then an output
// state that holds until the result is taken. A stalled receiver holds the
// result; the queue keeps taking days until it is full, then in_ch.ready drops.
// ---------------------------------------------------------------------------
module diurnal_temperature_curve_unit
    import dtc_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    dtc_in_if.sink     in_ch,
    dtc_out_if.source  out_ch
);

    logic job_valid, job_ready;
    job_t job;

    // intake and queue
    dtc_front #(.MAX_STEPS(MAX_STEPS)) u_front (
        .clk, .rst_n, .cfg_we, .cfg_wdata, .in_ch,
        .job_valid, .job_ready, .job
    );

    // step engine
    dtc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n, .job_valid, .job_ready, .job, .out_ch
    );

endmodule

// File: sv/dtc_front.sv
// ---------------------------------------------------------------------------
// dtc_front
// accepts day records, orders knots and pushes a job into a two-entry queue
// ---------------------------------------------------------------------------
module dtc_front
    import dtc_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    dtc_in_if.sink      in_ch,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    logic [IDX_W-1:0] rpd_reg;
    job_t             q_reg [2];
    logic             rd_ptr_reg, wr_ptr_reg;
    logic [1:0]       cnt_reg;
    job_t             newj;
    logic [IDX_W-1:0] wv;
    logic             push, pop;

    // clamp the register write
    always_comb
    begin
        wv = cfg_wdata;
        if (wv == '0)
            wv = IDX_W'(1);
        if (wv > IDX_W'(MAX_STEPS))
            wv = IDX_W'(MAX_STEPS);
    end

    // classify the incoming day
    always_comb
    begin
        newj.nrec   = rpd_reg;
        newj.pstep  = step_len(rpd_reg);
        newj.period = POS_W'(step_len(rpd_reg) * rpd_reg);
        newj.bad    = (in_ch.min_hour == in_ch.max_hour);
        if (in_ch.min_hour < in_ch.max_hour)
        begin
            newj.x1 = POS_W'(in_ch.min_hour); newj.y1 = in_ch.min_temp;
            newj.x2 = POS_W'(in_ch.max_hour); newj.y2 = in_ch.max_temp;
        end
        else
        begin
            newj.x1 = POS_W'(in_ch.max_hour); newj.y1 = in_ch.max_temp;
            newj.x2 = POS_W'(in_ch.min_hour); newj.y2 = in_ch.min_temp;
        end
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign job_valid   = (cnt_reg != 2'd0);
    assign pop         = job_valid && job_ready;
    assign job         = q_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= newj;
    end

    // queue control and register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpd_reg    <= RPD_RESET;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_we)
                rpd_reg <= wv;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: sv/dtc_back.sv
// ---------------------------------------------------------------------------
// dtc_back
// walks the steps of one job: segment select, serial divide, cubic, output
// ---------------------------------------------------------------------------
module dtc_back
    import dtc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    dtc_out_if.source   out_ch
);

    localparam int QW  = POS_W + FRAC_BITS + 2;       // dividend width
    localparam int TW  = FRAC_BITS + 4;               // signed t, |t| <= 4
    localparam int PW  = 2 * TW;
    localparam int HW  = FRAC_BITS + 9;
    localparam int DYW = TEMP_W + 2;
    localparam int YW  = DYW + HW + 1;
    localparam int CW  = $clog2(QW + 1);

    typedef enum logic [2:0] {S_IDLE, S_SEG, S_DIV, S_T2, S_T3, S_H, S_Y, S_OUT} state_t;

    state_t                  state_reg;
    job_t                    j_reg;
    logic [IDX_W-1:0]        i_reg;
    logic [POS_W-1:0]        p_reg;
    logic signed [TEMP_W-1:0] ya_reg;
    logic signed [DYW-1:0]   dy_reg;
    logic                    neg_reg, zero_reg;
    logic [QW-1:0]           num_reg, quo_reg;
    logic [POS_W:0]          den_reg;
    logic [POS_W+1:0]        rem_reg;
    logic [CW-1:0]           cnt_reg;
    logic signed [TW-1:0]    t_reg;
    logic signed [PW-1:0]    t2_reg, t3_reg;
    logic signed [HW-1:0]    h_reg;
    logic signed [YW-1:0]    prod_reg;
    logic                    ov_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    last_reg, badr_reg;

    // segment selection on the current step
    logic signed [POS_W+1:0] a_s, b_s, p_s, dn_s, nm_s;
    logic signed [TEMP_W-1:0] sya, syb;
    logic                    neg_s;
    always_comb
    begin
        p_s = (POS_W+2)'(signed'({1'b0, p_reg}));
        if (p_s < (POS_W+2)'(j_reg.x1))
        begin
            a_s = (POS_W+2)'(j_reg.x2) - (POS_W+2)'(signed'({1'b0, j_reg.period}));
            b_s = (POS_W+2)'(j_reg.x1); sya = j_reg.y2; syb = j_reg.y1;
        end
        else if (p_s < (POS_W+2)'(j_reg.x2))
        begin
            a_s = (POS_W+2)'(j_reg.x1); b_s = (POS_W+2)'(j_reg.x2);
            sya = j_reg.y1; syb = j_reg.y2;
        end
        else
        begin
            a_s = (POS_W+2)'(j_reg.x2);
            b_s = (POS_W+2)'(j_reg.x1) + (POS_W+2)'(signed'({1'b0, j_reg.period}));
            sya = j_reg.y2; syb = j_reg.y1;
        end
        dn_s = b_s - a_s;
        nm_s = p_s - a_s;
        // t is negative only for a nonzero offset against the segment direction
        neg_s = (nm_s != '0) && ((nm_s < 0) != (dn_s < 0));
    end

    // restoring divide step: remainder against 2*den
    logic [POS_W+2:0] trial;
    always_comb
        trial = {rem_reg, num_reg[QW-1]} - {1'b0, den_reg, 1'b0};

    // rounding of t: quotient of (2*num*one + den) / (2*den)
    logic signed [TW+1:0] tq;
    logic signed [TW-1:0] tsat;
    localparam logic signed [TW+1:0] TLIM = (TW+2)'(T_LIMIT) <<< FRAC_BITS;
    always_comb
    begin
        tq = neg_reg ? -(TW+2)'(quo_reg) : (TW+2)'(quo_reg);
        if (quo_reg > QW'(TLIM))
            tq = neg_reg ? -TLIM : TLIM;
        tsat = TW'(tq);
    end

    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
    logic signed [YW-1:0] yfull;
    always_comb
        yfull = YW'(ya_reg) + ((prod_reg + YW'(HALF)) >>> FRAC_BITS);

    assign job_ready        = (state_reg == S_IDLE);
    assign out_ch.valid     = (state_reg == S_OUT);
    assign out_ch.step_temp = temp_reg;
    assign out_ch.step_index = idx_reg;
    assign out_ch.last_step = last_reg;
    assign out_ch.bad_hours = badr_reg;

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        j_reg     <= job;
                        i_reg     <= '0;
                        p_reg     <= '0;
                        state_reg <= S_SEG;
                    end
                end
                S_SEG:
                begin
                    ya_reg   <= sya;
                    dy_reg   <= DYW'(syb) - DYW'(sya);
                    zero_reg <= (dn_s == '0);
                    neg_reg  <= neg_s;
                    den_reg  <= (dn_s < 0) ? (POS_W+1)'(-dn_s) : (POS_W+1)'(dn_s);
                    // dividend 2*|num|*one + |den|, minus |den| when t is negative
                    num_reg  <= (QW'((nm_s < 0) ? -nm_s : nm_s) << (FRAC_BITS + 1))
                              + (neg_s ? -QW'((dn_s < 0) ? -dn_s : dn_s)
                                       : QW'((dn_s < 0) ? -dn_s : dn_s));
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= CW'(QW);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (zero_reg || cnt_reg == '0)
                    begin
                        state_reg <= S_T2;
                        // negative: the magnitude needs a ceiling
                        if (!zero_reg && neg_reg && rem_reg != '0)
                            quo_reg <= quo_reg + QW'(1);
                    end
                    else
                    begin
                        num_reg <= {num_reg[QW-2:0], 1'b0};
                        if (!trial[POS_W+2])
                        begin
                            rem_reg <= trial[POS_W+1:0];
                            quo_reg <= {quo_reg[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[POS_W:0], num_reg[QW-1]};
                            quo_reg <= {quo_reg[QW-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                S_T2:
                begin
                    t_reg  <= tsat;
                    t2_reg <= (PW'(tsat) * PW'(tsat) + HALF) >>> FRAC_BITS;
                    state_reg <= S_T3;
                end
                S_T3:
                begin
                    t3_reg <= (t2_reg * PW'(t_reg) + HALF) >>> FRAC_BITS;
                    state_reg <= S_H;
                end
                S_H:
                begin
                    h_reg <= HW'(3 * t2_reg - 2 * t3_reg);
                    state_reg <= S_Y;
                end
                S_Y:
                begin
                    prod_reg  <= YW'(dy_reg) * YW'(h_reg);
                    state_reg <= S_OUT;
                    idx_reg   <= i_reg;
                    last_reg  <= (i_reg == j_reg.nrec - IDX_W'(1));
                    badr_reg  <= j_reg.bad;
                    ov_reg    <= zero_reg;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        if (last_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            i_reg <= i_reg + IDX_W'(1);
                            p_reg <= p_reg + j_reg.pstep;
                            state_reg <= S_SEG;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // final value with saturation, zero for bad hours, formed while the result is held
    always_comb
    begin
        logic signed [YW-1:0] y;
        y = ov_reg ? YW'(ya_reg) : yfull;
        if (y > YW'(16383))
            y = YW'(16383);
        if (y < -YW'(16384))
            y = -YW'(16384);
        temp_reg = badr_reg ? '0 : TEMP_W'(y);
    end

endmodule

// File: tb/sv/tb_diurnal_temperature_curve_unit.sv
// ---------------------------------------------------------------------------
// tb_diurnal_temperature_curve_unit
// self-checking bench: day records in, per-step temperatures checked against
// a behavioral hermite curve predictor under bursty input and output stalls
// ---------------------------------------------------------------------------
module tb_diurnal_temperature_curve_unit;
    import dtc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_DAYS    = 300;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [IDX_W-1:0]         index;
        logic                     last;
        logic                     bad;
    } step_t;

    typedef struct {
        logic [HOUR_W-1:0]        hmin;
        logic signed [TEMP_W-1:0] tmin;
        logic [HOUR_W-1:0]        hmax;
        logic signed [TEMP_W-1:0] tmax;
        logic signed [TEMP_W-1:0] first_temp; // typed-in value of step 0
        bit                       has_first;
    } day_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [4:0] cfg_wdata;

    dtc_in_if  in_ch ();
    dtc_out_if out_ch ();

    diurnal_temperature_curve_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    step_t       expected_steps[$];
    int unsigned steps_per_day_model;
    int          mismatch_count;
    int          idle_cycles;
    bit          stall_enable;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // floor division, b > 0
    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic longint round_div(longint a, longint b);
        return floor_div(2 * a + b, 2 * b);
    endfunction

    // predict the per-step curve of one day and queue it
    task automatic predict_day(input logic [HOUR_W-1:0] hmin, input logic signed [TEMP_W-1:0] tmin,
                               input logic [HOUR_W-1:0] hmax, input logic signed [TEMP_W-1:0] tmax);
        longint one, n, dlen, period, x0, x1, x2, x3, y0, y1, y2, y3;
        longint pos, a, b, ya, yb, den, num, y, t, t2, t3, h;
        bit bad;
        step_t s;
        one = longint'(1) << FRAC_BITS_DEF;
        n = steps_per_day_model;
        dlen = HOURS_PER_DAY / n;
        period = SUB_HOUR * dlen * n;
        bad = (hmin == hmax);
        if (hmin < hmax)
        begin
            x1 = hmin; y1 = tmin; x2 = hmax; y2 = tmax;
        end
        else
        begin
            x1 = hmax; y1 = tmax; x2 = hmin; y2 = tmin;
        end
        x0 = x2 - period; y0 = y2;
        x3 = x1 + period; y3 = y1;
        for (longint i = 0; i < n; i++)
        begin
            pos = SUB_HOUR * dlen * i;
            if (pos < x1)
            begin
                a = x0; b = x1; ya = y0; yb = y1;
            end
            else if (pos < x2)
            begin
                a = x1; b = x2; ya = y1; yb = y2;
            end
            else
            begin
                a = x2; b = x3; ya = y2; yb = y3;
            end
            den = b - a;
            num = pos - a;
            if (den == 0)
                y = ya;
            else
            begin
                if (den < 0)
                begin
                    den = -den;
                    num = -num;
                end
                t = round_div(num * one, den);
                if (t > T_LIMIT * one)
                    t = T_LIMIT * one;
                if (t < -T_LIMIT * one)
                    t = -T_LIMIT * one;
                t2 = round_div(t * t, one);
                t3 = round_div(t2 * t, one);
                h = 3 * t2 - 2 * t3;
                y = ya + round_div((yb - ya) * h, one);
            end
            if (y > 16383)
                y = 16383;
            if (y < -16384)
                y = -16384;
            if (bad)
                y = 0;
            s.temp  = TEMP_W'(y);
            s.index = IDX_W'(i);
            s.last  = (i == n - 1);
            s.bad   = bad;
            expected_steps.push_back(s);
        end
    endtask

    task automatic report_mismatch(input string what, input step_t exp_s, input step_t act_s);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected temp=%0d idx=%0d last=%0b bad=%0b, got temp=%0d idx=%0d last=%0b bad=%0b",
                     what, exp_s.temp, exp_s.index, exp_s.last, exp_s.bad,
                     act_s.temp, act_s.index, act_s.last, act_s.bad);
    endtask

    // receiver stall pattern and result checking
    int unsigned stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_phase  <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (!stall_enable)
                out_ch.ready <= 1'b1;
            else if (stall_phase[8])
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 13 != 0);
        end
    end

    always @(posedge clk)
    begin
        step_t act_s;
        step_t exp_s;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            act_s.temp  = out_ch.step_temp;
            act_s.index = out_ch.step_index;
            act_s.last  = out_ch.last_step;
            act_s.bad   = out_ch.bad_hours;
            if (expected_steps.size() == 0)
                report_mismatch("unexpected step", '0, act_s);
            else
            begin
                exp_s = expected_steps.pop_front();
                if (act_s !== exp_s)
                    report_mismatch("step", exp_s, act_s);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("diurnal_temperature_curve_unit regression: fail");
            $finish;
        end
    end

    // one day transfer
    task automatic send_day(input logic [HOUR_W-1:0] hmin, input logic signed [TEMP_W-1:0] tmin,
                            input logic [HOUR_W-1:0] hmax, input logic signed [TEMP_W-1:0] tmax);
        in_ch.valid    <= 1'b1;
        in_ch.min_hour <= hmin;
        in_ch.min_temp <= tmin;
        in_ch.max_hour <= hmax;
        in_ch.max_temp <= tmax;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_day(hmin, tmin, hmax, tmax);
    endtask

    task automatic drop_valid();
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        @(posedge clk);
        while (expected_steps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write while idle
    task automatic write_steps(input logic [4:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (value == 0)
            steps_per_day_model = 1;
        else if (value > MAX_STEPS_DEF)
            steps_per_day_model = MAX_STEPS_DEF;
        else
            steps_per_day_model = value;
    endtask

    function automatic logic signed [TEMP_W-1:0] rand_temp();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return TEMP_W'($urandom);
        else if (sel == 1)
            return (sel[0]) ? 15'sd10000 : -15'sd10000;
        return TEMP_W'(int'($urandom_range(0, 20000)) - 10000);
    endfunction

    function automatic logic [HOUR_W-1:0] rand_hour();
        if ($urandom_range(0, 15) == 0)
            return HOUR_W'($urandom);
        return HOUR_W'($urandom_range(0, 383));
    endfunction

    day_row_t day_table[$];

    task automatic fill_day_table();
        // equal hours give zero temperature
        day_table.push_back('{9'd100, 15'sd500, 9'd100, 15'sd900, 15'sd0, 1'b1});
        day_table.push_back('{9'd0, -15'sd10000, 9'd0, 15'sd10000, 15'sd0, 1'b1});
        // a knot at midnight: step 0 sits on the knot
        day_table.push_back('{9'd0, -15'sd10000, 9'd224, 15'sd10000, -15'sd10000, 1'b1});
        day_table.push_back('{9'd0, 15'sd10000, 9'd383, -15'sd10000, 15'sd10000, 1'b1});
        day_table.push_back('{9'd383, -15'sd10000, 9'd0, 15'sd10000, 15'sd10000, 1'b1});
        day_table.push_back('{9'd96, 15'sd1200, 9'd240, 15'sd2500, 15'sd0, 1'b0});
        day_table.push_back('{9'd240, 15'sd3000, 9'd96, -15'sd500, 15'sd0, 1'b0});
        day_table.push_back('{9'd1, 15'sd10000, 9'd382, -15'sd10000, 15'sd0, 1'b0});
        // hours beyond a day and out of range temperatures: extrapolation, saturation
        day_table.push_back('{9'd511, 15'sd16383, 9'd400, -15'sd16384, 15'sd0, 1'b0});
        day_table.push_back('{9'd450, -15'sd16384, 9'd20, 15'sd16383, 15'sd0, 1'b0});
        day_table.push_back('{9'd256, 15'sd0, 9'd255, 15'sd0, 15'sd0, 1'b1});
        day_table.push_back('{9'd170, -15'sd1, 9'd85, 15'sd1, 15'sd0, 1'b0});
    endtask

    task automatic run_day_table();
        step_t s;
        for (int r = 0; r < day_table.size(); r++)
        begin
            send_day(day_table[r].hmin, day_table[r].tmin, day_table[r].hmax, day_table[r].tmax);
            if (day_table[r].has_first)
            begin
                s = expected_steps[expected_steps.size() - steps_per_day_model];
                if (s.temp !== day_table[r].first_temp)
                    report_mismatch("table row", '{day_table[r].first_temp, 5'd0, 1'b0, s.bad}, s);
            end
        end
    endtask

    // bursty random days
    task automatic run_random_days(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 6);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                send_day(rand_hour(), rand_temp(), rand_hour(), rand_temp());
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                drop_valid();
                repeat ($urandom_range(1, 60)) @(posedge clk);
            end
            // hold off at most once, when half the days are sent, until everything is back
            if (sent == count / 2)
                wait_drained();
        end
    endtask

    initial
    begin
        logic [4:0] phase_setting[6] = '{5'd24, 5'd1, 5'd0, 5'd31, 5'd7, 5'd24};
        int days_per_phase;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.min_hour = '0;
        in_ch.min_temp = '0;
        in_ch.max_hour = '0;
        in_ch.max_temp = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        stall_enable   = 1'b0;
        steps_per_day_model = RPD_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset setting, no stalls
        fill_day_table();
        run_day_table();
        wait_drained();

        stall_enable = 1'b1;
        days_per_phase = RANDOM_DAYS / 6;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_steps(phase_setting[ph]);
            if (ph == 5)
                write_steps(5'($urandom_range(2, 23)));
            run_random_days(days_per_phase);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("diurnal_temperature_curve_unit regression: pass");
        else
            $display("diurnal_temperature_curve_unit regression: fail");
        $finish;
    end

endmodule
